>>> rtl/core/integer_to_ascii_radix_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the radix text converter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// hold the consequent in the same cycle as the antecedent
`define ITOAR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// hold the consequent in the cycle after the antecedent
`define ITOAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/itoar_pkg.sv
// ----------------------------------------------------------------------------
// itoar_pkg
// Types, constants and the digit table of the radix text converter.
// ----------------------------------------------------------------------------
package itoar_pkg;

    localparam int NUM_W       = 32;
    localparam int RADIX_W     = 8;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 6;
    localparam int MAX_DIGITS  = 32;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_CYC = 8;
    localparam int STEPS       = NUM_W / BITS_PER_CYC;
    localparam int STEP_W      = $clog2(STEPS);
    localparam int IN_W        = NUM_W + RADIX_W;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 8'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_DIGIT,
        S_TERM
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic              in_radix_ok;
        logic              div_last;
        logic              neg10;
        logic              cnt_one;
        logic [CHAR_W-1:0] top_char;
    } t_dp_stat;

    // 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] f_digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d < DIGIT_W'(10)) begin
            return CHAR_ZERO + ext;
        end
        return CHAR_ALPHA + ext;
    endfunction

endpackage

>>> rtl/core/itoar_dp.sv
// ----------------------------------------------------------------------------
// itoar_dp
// Magnitude divider, eight quotient bits per cycle, and a digit stack.
// ----------------------------------------------------------------------------
module itoar_dp
    import itoar_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [NUM_W-1:0]    i_number,
    input  logic [RADIX_W-1:0]  i_radix,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat
);

    logic [NUM_W-1:0]   r_quot, n_quot;
    logic [DIGIT_W-1:0] r_rem,  n_rem;
    logic [DIGIT_W-1:0] r_radix;
    logic               r_neg10;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIGIT_W-1:0] r_stack [MAX_DIGITS];

    logic               step_end;

    always_comb begin
        logic [DIGIT_W:0] t;
        n_quot = r_quot;
        n_rem  = r_rem;
        for (int k = 0; k < BITS_PER_CYC; k++) begin
            t      = {n_rem, n_quot[NUM_W-1]};
            n_quot = {n_quot[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                n_rem     = DIGIT_W'(t - {1'b0, r_radix});
                n_quot[0] = 1'b1;
            end else begin
                n_rem = t[DIGIT_W-1:0];
            end
        end
    end

    assign step_end = (r_step == STEP_W'(STEPS - 1));

    always_comb begin
        o_stat.in_radix_ok = i_radix inside {[RADIX_MIN:RADIX_MAX]};
        o_stat.div_last    = step_end &&
                             ((n_quot == '0) || (r_cnt == CNT_W'(MAX_DIGITS - 1)));
        o_stat.neg10       = r_neg10;
        o_stat.cnt_one     = (r_cnt == CNT_W'(1));
        o_stat.top_char    = f_digit_char(r_stack[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.load) begin
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_step <= r_step + STEP_W'(1);
            if (step_end) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot  <= i_number[NUM_W-1] ? ('0 - i_number) : i_number;
            r_rem   <= '0;
            r_radix <= i_radix[DIGIT_W-1:0];
            r_neg10 <= i_number[NUM_W-1] && (i_radix == RADIX_DEC);
        end else if (i_cmd.step) begin
            r_quot <= n_quot;
            r_rem  <= step_end ? '0 : n_rem;
        end
    end

    // push on the last step of a digit, pop from the same end, entry 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && step_end) begin
            r_stack[0] <= n_rem;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

endmodule

>>> rtl/core/itoar_ctrl.sv
// ----------------------------------------------------------------------------
// itoar_ctrl
// Sequencer of division and emission, with the output register.
// ----------------------------------------------------------------------------
module itoar_ctrl
    import itoar_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_out_char,
    output logic              o_out_last,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    t_state            r_state, n_state;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;
    logic              out_load;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char <= n_out_char;
            r_out_last <= n_out_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        n_out_char = CHAR_NUL;
        n_out_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.in_radix_ok ? S_DIV : S_TERM;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = i_stat.neg10 ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_char = CHAR_MINUS;
                    n_state    = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_cmd.pop  = 1'b1;
                    n_out_char = i_stat.top_char;
                    if (i_stat.cnt_one) begin
                        n_state = S_TERM;
                    end
                end
            end
            S_TERM: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

>>> rtl/core/integer_to_ascii_radix_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_core
// Signed 32-bit value to ASCII text in radix 2 to 36.
// ----------------------------------------------------------------------------
// Input stream s_axis: one transfer carries a value and a radix. Output
// stream m_axis: one transfer per character, most significant digit first,
// digits 0-9 then A-Z, then a NUL character with tlast high. Radix 10 puts a
// minus sign before negative values; other radices write the magnitude. A
// radix outside 2..36 gives the NUL transfer alone.
// Timing: the input is taken in the idle state, then each digit is a full
// 32-bit division in the shared divider, which retires 8 quotient bits per
// cycle. Emission is one character per cycle from a digit stack while the
// receiver is ready.
// One item is converted at a time; the next is taken once the NUL transfer
// sits in the output register, even while it waits for the receiver.
// A receiver stall holds the output register and pauses emission.
// Reset (synchronous, active low) empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_core
    import itoar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,   // number[31:0], radix[39:32]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [CHAR_W-1:0]  m_axis_tdata,   // char_code[7:0]
    output logic               m_axis_tlast
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    itoar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    itoar_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_number (s_axis_tdata[NUM_W-1:0]),
        .i_radix  (s_axis_tdata[IN_W-1:NUM_W]),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat)
    );

endmodule

>>> rtl/core/itoar_checker.sv
// ----------------------------------------------------------------------------
// itoar_checker
// Port-level checks of the radix text converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_core_defines.svh"

module itoar_checker
    import itoar_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [CHAR_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast
);

    `ITOAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output transfer changed")
    `ITOAR_ASSERT_SAME(a_last_nul, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata == CHAR_NUL, "last transfer is not NUL")
    `ITOAR_ASSERT_SAME(a_char_nonnul, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata != CHAR_NUL, "NUL inside text")
    `ITOAR_ASSERT_SAME(a_busy_in_text, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input taken while text in flight")

endmodule

bind integer_to_ascii_radix_core itoar_checker u_itoar_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
